FILE: rtl/core/rme_pkg.sv
// Shared constants for the RSA modular exponentiation unit.
package rme_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int CSR_INDEX_BITS     = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

endpackage

FILE: rtl/core/rsa_modular_exponentiation_unit.sv
// Top level: configuration registers and square-and-multiply sequencer.
// Computes base^e mod modulus, e being the public exponent (mode 0) or the private
// exponent (mode 1). One item is in flight at a time; req_stall is high from accept
// until the result beat is taken. An item with a zero exponent or zero modulus goes
// straight to the result state. Otherwise all VALUE_BITS exponent bits are scanned, each
// costing one modular squaring plus, for a one bit, one modular multiply; every multiply
// runs on a single bit-serial unit.
module rsa_modular_exponentiation_unit #(
   parameter int VALUE_BITS = rme_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [VALUE_BITS-1:0]             req_base,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [VALUE_BITS-1:0]             rsp_result,
   input  logic                              csr_wr_en,
   input  logic [rme_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]             csr_wdata
);
   import rme_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(VALUE_BITS - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SQ_GO   = 3'd1;
   localparam logic [2:0] ST_SQ_WAIT = 3'd2;
   localparam logic [2:0] ST_MU_GO   = 3'd3;
   localparam logic [2:0] ST_MU_WAIT = 3'd4;
   localparam logic [2:0] ST_OUT     = 3'd5;

   logic [VALUE_BITS-1:0] modulus_ff, public_exp_ff, private_exp_ff;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] exp_ff, exp_in;
   logic [VALUE_BITS-1:0] base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]   bit_ff, bit_in;

   logic                  mul_start;
   logic                  mul_busy;
   logic                  mul_done;
   logic [VALUE_BITS-1:0] mul_y;
   logic [VALUE_BITS-1:0] mul_product;
   logic [VALUE_BITS-1:0] exp_sel;
   logic                  req_beat;

   localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= ONE;
         public_exp_ff  <= VALUE_BITS'(3);
         private_exp_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODULUS:          modulus_ff     <= csr_wdata;
            CSR_PUBLIC_EXPONENT:  public_exp_ff  <= csr_wdata;
            CSR_PRIVATE_EXPONENT: private_exp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_beat = req_valid && !req_stall;
   assign exp_sel  = (req_mode == MODE_DECRYPT) ? private_exp_ff : public_exp_ff;
   assign mul_start = (state_ff == ST_SQ_GO) || (state_ff == ST_MU_GO);
   assign mul_y     = (state_ff == ST_MU_GO) ? base_ff : acc_ff;

   always_comb begin
      state_in = state_ff;
      exp_in   = exp_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_beat) begin
               exp_in  = exp_sel;
               base_in = req_base;
               bit_in  = LAST_BIT;
               if (exp_sel == '0) begin
                  acc_in   = ONE;
                  state_in = ST_OUT;
               end else if (modulus_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  // start from 1 mod m so acc always stays reduced
                  acc_in   = (modulus_ff == ONE) ? '0 : ONE;
                  state_in = ST_SQ_GO;
               end
            end
         end
         ST_SQ_GO: state_in = ST_SQ_WAIT;
         ST_MU_GO: state_in = ST_MU_WAIT;
         ST_SQ_WAIT, ST_MU_WAIT: begin
            if (mul_done) begin
               acc_in = mul_product;
               if ((state_ff == ST_SQ_WAIT) && exp_ff[VALUE_BITS-1]) begin
                  state_in = ST_MU_GO;
               end else begin
                  exp_in = {exp_ff[VALUE_BITS-2:0], 1'b0};
                  bit_in = bit_ff - 1'b1;
                  state_in = (bit_ff == '0) ? ST_OUT : ST_SQ_GO;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      exp_ff  <= exp_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      bit_ff  <= bit_in;
   end

   rme_mulmod #(
      .VALUE_BITS(VALUE_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x_in    (acc_ff),
      .y_in    (mul_y),
      .m_in    (modulus_ff),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);
   assign rsp_result = acc_ff;

`ifndef ASSERT_OFF
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> ((state_ff == ST_SQ_WAIT) || (state_ff == ST_MU_WAIT)))
      else $error("multiplier result with no operation pending");
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_GO) |-> (acc_ff < modulus_ff))
      else $error("accumulator not reduced below modulus");
   a_launch_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiply launched while unit busy");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff != ST_IDLE))
      else $error("accepted beat not taken up");
`endif

endmodule

FILE: rtl/core/rme_mulmod.sv
// Bit-serial interleaved modular multiplier: product = (x * y) mod m, one bit of y per cycle.
module rme_mulmod #(
   parameter int VALUE_BITS = rme_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] x_in,
   input  logic [VALUE_BITS-1:0] y_in,
   input  logic [VALUE_BITS-1:0] m_in,
   output logic                  busy,
   output logic                  done,
   output logic [VALUE_BITS-1:0] product
);
   import rme_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam int EXT_BITS = VALUE_BITS + 2;
   localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] x_ff, x_in_nxt;
   logic [VALUE_BITS-1:0] y_ff, y_in_nxt;
   logic [VALUE_BITS-1:0] r_ff, r_in;

   logic [EXT_BITS-1:0] m_ext;
   logic [EXT_BITS-1:0] dbl;
   logic [EXT_BITS-1:0] dbl_red;
   logic [EXT_BITS-1:0] sum;
   logic [EXT_BITS-1:0] sum_red;

   // r stays below m: 2r < 2m, one subtract; then + x < 2m, one subtract.
   always_comb begin
      m_ext   = {2'b00, m_in};
      dbl     = {1'b0, r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
      sum     = dbl_red + {2'b00, (x_ff & {VALUE_BITS{y_ff[VALUE_BITS-1]}})};
      sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      x_in_nxt = x_ff;
      y_in_nxt = y_ff;
      r_in     = r_ff;
      if (busy_ff) begin
         r_in     = sum_red[VALUE_BITS-1:0];
         y_in_nxt = {y_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         cnt_in   = LAST_BIT;
         x_in_nxt = x_in;
         y_in_nxt = y_in;
         r_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in_nxt;
      y_ff   <= y_in_nxt;
      r_ff   <= r_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = r_ff;

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && $past(busy_ff)) |-> (r_ff < m_in))
      else $error("partial remainder not reduced");
`endif

endmodule

FILE: sim/rsa_modular_exponentiation_unit_test.sv
// Self-checking testbench for the RSA modular exponentiation unit.
module rsa_modular_exponentiation_unit_test;
   import rme_pkg::*;

   localparam int VB = VALUE_BITS_DEFAULT;
   localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};
   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int LONG_HOLD = 3000;
   localparam int HOLD_AT_RESULT = 120;
   localparam int DRAIN_CYCLES = 2100;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ROUNDS = 7;
   localparam int ROUND_ITEMS = 39;

   class power_scoreboard;
      bit [VB-1:0] modulus = VB'(1);
      bit [VB-1:0] public_exp = VB'(3);
      bit [VB-1:0] private_exp = '0;
      bit [VB-1:0] expected_powers[$];
      int unsigned mismatches = 0;

      function void set_register(logic [CSR_INDEX_BITS-1:0] index, bit [VB-1:0] value);
         case (index)
            CSR_MODULUS:          modulus = value;
            CSR_PUBLIC_EXPONENT:  public_exp = value;
            CSR_PRIVATE_EXPONENT: private_exp = value;
            default: ;
         endcase
      endfunction

      // left-to-right square-and-multiply, every product reduced
      function bit [VB-1:0] mod_power(bit [VB-1:0] b, bit [VB-1:0] e);
         bit [63:0] acc;
         if (e == 0) return VB'(1);
         if (modulus == 0) return '0;
         acc = 64'd1;
         for (int i = VB - 1; i >= 0; i--) begin
            acc = (acc * acc) % {33'd0, modulus};
            if (e[i]) acc = (acc * {33'd0, b}) % {33'd0, modulus};
         end
         return acc[VB-1:0];
      endfunction

      function void note_request(logic mode, logic [VB-1:0] base);
         expected_powers.push_back(
            mod_power(base, (mode == MODE_DECRYPT) ? private_exp : public_exp));
      endfunction

      function void check_result(logic [VB-1:0] actual);
         bit [VB-1:0] want;
         if (expected_powers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("unexpected result beat: %0d", actual);
            return;
         end
         want = expected_powers.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result mismatch: expected %0d, got %0d", want, actual);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_mode = MODE_ENCRYPT;
   logic [VB-1:0] req_base = '0;
   logic rsp_stall = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODULUS;
   logic [VB-1:0] csr_wdata = '0;
   wire req_stall;
   wire rsp_valid;
   wire [VB-1:0] rsp_result;

   power_scoreboard book = new();
   bit idle_on = 1'b1;
   int unsigned cycle_count = 0;

   rsa_modular_exponentiation_unit #(.VALUE_BITS(VB)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_base(req_base),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result(rsp_result),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** rsa_modular_exponentiation_unit: FAILED **");
      $finish;
   end

   function automatic int draw_gap();
      if (!idle_on) return 0;
      return int'($urandom_range(0, 13));
   endfunction

   function automatic logic [VB-1:0] pick_modulus();
      logic [VB-1:0] m;
      case ($urandom_range(0, 5))
         0: m = VB'(1);
         1: m = VB'($urandom_range(2, 255));
         2: m = VB'(VALUE_MAX - $urandom_range(0, 15));
         3: m = VB'($urandom_range(256, 65535));
         default: m = VB'($urandom);
      endcase
      if (m == 0) m = VB'(1);
      return m;
   endfunction

   function automatic logic [VB-1:0] pick_exponent();
      logic [VB-1:0] e;
      case ($urandom_range(0, 5))
         0: e = '0;
         1: e = VB'(1);
         2: e = VB'($urandom_range(2, 65537));
         3: e = VALUE_MAX;
         default: e = VB'($urandom);
      endcase
      return e;
   endfunction

   function automatic logic [VB-1:0] pick_base(logic [VB-1:0] m);
      logic [VB-1:0] b;
      case ($urandom_range(0, 6))
         0: b = '0;
         1: b = VB'(1);
         2: b = VALUE_MAX;
         3: b = m - 1'b1;
         4, 5: b = VB'($urandom % m);
         default: b = VB'($urandom);
      endcase
      return b;
   endfunction

   // called at a rising edge; returns at the accepting edge or after the gap
   task automatic send_beat(input logic mode, input logic [VB-1:0] base);
      int gap;
      req_mode <= mode;
      req_base <= base;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(mode, base);
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.expected_powers.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [VB-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      book.set_register(index, value);
   endtask

   task automatic configure(input logic [VB-1:0] m_val, input logic [VB-1:0] pub_val,
                            input logic [VB-1:0] priv_val);
      write_register(CSR_MODULUS, m_val);
      write_register(CSR_PUBLIC_EXPONENT, pub_val);
      write_register(CSR_PRIVATE_EXPONENT, priv_val);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : result_side
      int hold;
      int unsigned taken;
      taken = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      hold = draw_gap();
      forever begin
         if (hold > 0) begin
            // hold off until a beat is offered, then keep it waiting
            rsp_stall <= 1'b1;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            repeat (hold - 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         book.check_result(rsp_result);
         taken++;
         hold = (taken == HOLD_AT_RESULT) ? LONG_HOLD : draw_gap();
      end
   end

   initial begin : stimulus
      int round;
      logic [VB-1:0] m;
      logic mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: modulus one, zero private exponent
      send_beat(MODE_ENCRYPT, '0);
      send_beat(MODE_ENCRYPT, VALUE_MAX);
      send_beat(MODE_DECRYPT, '0);
      send_beat(MODE_DECRYPT, VALUE_MAX);
      drain();

      configure(VALUE_MAX, VALUE_MAX, '0);
      send_beat(MODE_ENCRYPT, '0);
      send_beat(MODE_ENCRYPT, VB'(1));
      send_beat(MODE_ENCRYPT, VB'(2));
      send_beat(MODE_ENCRYPT, VALUE_MAX);
      send_beat(MODE_ENCRYPT, VALUE_MAX - 1'b1);
      send_beat(MODE_DECRYPT, VB'(12345));
      drain();

      configure(VB'(1), VB'(1), VALUE_MAX);
      send_beat(MODE_ENCRYPT, '0);
      send_beat(MODE_ENCRYPT, VALUE_MAX);
      send_beat(MODE_DECRYPT, VB'(1));
      send_beat(MODE_DECRYPT, 31'h5555_5555);
      drain();

      // small textbook key pair, round trip plus bases above the modulus
      configure(VB'(3233), VB'(17), VB'(2753));
      send_beat(MODE_ENCRYPT, VB'(65));
      send_beat(MODE_DECRYPT, VB'(2790));
      send_beat(MODE_ENCRYPT, VB'(3232));
      send_beat(MODE_ENCRYPT, VB'(5000));
      send_beat(MODE_DECRYPT, VB'(3233));
      send_beat(MODE_DECRYPT, VALUE_MAX);
      drain();

      for (round = 0; round < RANDOM_ROUNDS; round++) begin
         idle_on = (round != 2) && (round != 5);
         m = pick_modulus();
         configure(m, pick_exponent(), pick_exponent());
         repeat (ROUND_ITEMS) begin
            mode = $urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT;
            send_beat(mode, pick_base(m));
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.expected_powers.size() == 0) begin
         $display("** rsa_modular_exponentiation_unit: PASSED **");
      end else begin
         $display("** rsa_modular_exponentiation_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: rsa_modular_exponentiation_unit.f
rtl/core/rme_pkg.sv
rtl/core/rme_mulmod.sv
rtl/core/rsa_modular_exponentiation_unit.sv
sim/rsa_modular_exponentiation_unit_test.sv
